// ===== rtl/core/stq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stq_pkg
// Shared codes, constants and controller/datapath interface types for the
// sorted timeout queue.
// ----------------------------------------------------------------------------
package stq_pkg;

    localparam int NUM_SLOTS_DEF = 32;
    localparam int BURST_MAX     = 31;
    localparam logic [31:0] END_DEADLINE = 32'hffff_ffff;

    // request actions
    localparam logic [2:0] ACT_ALLOC   = 3'd0;
    localparam logic [2:0] ACT_FREE    = 3'd1;
    localparam logic [2:0] ACT_SETTAG  = 3'd2;
    localparam logic [2:0] ACT_ARM     = 3'd3;
    localparam logic [2:0] ACT_CANCEL  = 3'd4;
    localparam logic [2:0] ACT_CANCALL = 3'd5;
    localparam logic [2:0] ACT_TICK    = 3'd6;

    // result kinds
    localparam logic [1:0] KIND_ACK     = 2'd0;
    localparam logic [1:0] KIND_DELIVER = 2'd1;
    localparam logic [1:0] KIND_SWITCH  = 2'd2;

    // slot modes
    localparam logic [1:0] MODE_FREE  = 2'd0;
    localparam logic [1:0] MODE_ALLOC = 2'd1;
    localparam logic [1:0] MODE_RUN   = 2'd2;

    // memory read address sources
    localparam logic [1:0] RA_TGT  = 2'd0;
    localparam logic [1:0] RA_HEAD = 2'd1;
    localparam logic [1:0] RA_LKD  = 2'd2;
    localparam logic [1:0] RA_IDX  = 2'd3;

    // mode / mark address sources
    localparam logic [1:0] MA_TGT = 2'd0;
    localparam logic [1:0] MA_IDX = 2'd1;
    localparam logic [1:0] MA_CUR = 2'd2;

    // head update sources
    localparam logic [1:0] HD_NONE = 2'd0;
    localparam logic [1:0] HD_NXT  = 2'd1;
    localparam logic [1:0] HD_TGT  = 2'd2;
    localparam logic [1:0] HD_CUR  = 2'd3;

    // ack slot sources
    localparam logic [1:0] AS_SID  = 2'd0;
    localparam logic [1:0] AS_IDX  = 2'd1;
    localparam logic [1:0] AS_ZERO = 2'd2;

    typedef struct packed {
        logic       capture;
        logic       rd_en;
        logic [1:0] ra_sel;
        logic [1:0] mode_sel;
        logic       mode_we;
        logic [1:0] mode_val;
        logic       mark_we;
        logic       mark_item;
        logic       tm_we;
        logic       dl_we;
        logic       lk_w_unlink;
        logic       lk_w_tgt;
        logic       lk_w_prev;
        logic [1:0] head_sel;
        logic       nxt_load;
        logic       idx_init;
        logic       idx_inc;
        logic       tgt_from_idx;
        logic       tk_step;
        logic       out_ack;
        logic [1:0] ack_slot_sel;
        logic       ack_st;
        logic       out_pend;
        logic       pend_last;
        logic       out_ts;
    } stq_cmd_t;

    typedef struct packed {
        logic [2:0] act;
        logic       ok;
        logic       mode_free;
        logic       mode_run;
        logic       head_is_tgt;
        logic       lk_hit;
        logic       ins_hit;
        logic       cur_is_head;
        logic       due;
        logic       emit_block;
        logic       idx_end;
        logic       ca_match;
        logic       pend_v;
        logic       ts;
        logic       out_free;
    } stq_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/stq_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stq_ctrl
// Sequencer for the timer queue: dispatches requests, walks the list for
// unlink, insert and expiry, scans slots for alloc and cancel-all.
// ----------------------------------------------------------------------------
module stq_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire stq_pkg::stq_stat_t st,
    output stq_pkg::stq_cmd_t      cmd
);
    import stq_pkg::*;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_DISP    = 5'd1;
    localparam logic [4:0] S_UL_S    = 5'd2;
    localparam logic [4:0] S_UL_N    = 5'd3;
    localparam logic [4:0] S_UL_W    = 5'd4;
    localparam logic [4:0] S_FREEFIN = 5'd5;
    localparam logic [4:0] S_CANFIN  = 5'd6;
    localparam logic [4:0] S_ARMINS  = 5'd7;
    localparam logic [4:0] S_IN_W    = 5'd8;
    localparam logic [4:0] S_IN_P    = 5'd9;
    localparam logic [4:0] S_AL_SCAN = 5'd10;
    localparam logic [4:0] S_CA_RD   = 5'd11;
    localparam logic [4:0] S_CA_CHK  = 5'd12;
    localparam logic [4:0] S_CA_FREE = 5'd13;
    localparam logic [4:0] S_TK      = 5'd14;
    localparam logic [4:0] S_TK_CHK  = 5'd15;
    localparam logic [4:0] S_TK_FIN  = 5'd16;
    localparam logic [4:0] S_ACK     = 5'd17;

    logic [4:0] state_reg, state_next;
    logic [4:0] ret_reg, ret_next;
    logic       ack_st_reg, ack_st_next;
    logic [1:0] ack_sel_reg, ack_sel_next;

    // state and return registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            ret_reg     <= S_IDLE;
            ack_st_reg  <= 1'b0;
            ack_sel_reg <= AS_SID;
        end else begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            ack_st_reg  <= ack_st_next;
            ack_sel_reg <= ack_sel_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    // next state and commands
    always_comb begin
        cmd          = '0;
        state_next   = state_reg;
        ret_next     = ret_reg;
        ack_st_next  = ack_st_reg;
        ack_sel_next = ack_sel_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISP;
                end
            end
            S_DISP: begin
                ack_sel_next = AS_SID;
                ack_st_next  = 1'b1;
                state_next   = S_ACK;
                cmd.mode_sel = MA_TGT;
                case (st.act)
                    ACT_ALLOC: begin
                        cmd.idx_init = 1'b1;
                        state_next   = S_AL_SCAN;
                    end
                    ACT_FREE: begin
                        if (st.ok) begin
                            if (st.mode_run) begin
                                ret_next   = S_FREEFIN;
                                state_next = S_UL_S;
                            end else begin
                                state_next = S_FREEFIN;
                            end
                        end
                    end
                    ACT_SETTAG: begin
                        if (st.ok) begin
                            cmd.tm_we     = 1'b1;
                            cmd.mark_we   = 1'b1;
                            cmd.mark_item = 1'b1;
                            ack_st_next   = 1'b0;
                        end
                    end
                    ACT_ARM: begin
                        if (st.ok && !st.mode_free) begin
                            if (st.mode_run) begin
                                ret_next   = S_ARMINS;
                                state_next = S_UL_S;
                            end else begin
                                state_next = S_ARMINS;
                            end
                        end
                    end
                    ACT_CANCEL: begin
                        if (st.ok && st.mode_run) begin
                            ret_next   = S_CANFIN;
                            state_next = S_UL_S;
                        end
                    end
                    ACT_CANCALL: begin
                        cmd.idx_init = 1'b1;
                        state_next   = S_CA_RD;
                    end
                    ACT_TICK: begin
                        state_next = S_TK;
                    end
                    default: begin
                        state_next = S_ACK;
                    end
                endcase
            end
            // unlink: fetch successor of target
            S_UL_S: begin
                cmd.rd_en  = 1'b1;
                cmd.ra_sel = RA_TGT;
                state_next = S_UL_N;
            end
            S_UL_N: begin
                cmd.nxt_load = 1'b1;
                if (st.head_is_tgt) begin
                    cmd.head_sel = HD_NXT;
                    state_next   = ret_reg;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.ra_sel = RA_HEAD;
                    state_next = S_UL_W;
                end
            end
            // unlink: walk to predecessor
            S_UL_W: begin
                if (st.lk_hit) begin
                    cmd.lk_w_unlink = 1'b1;
                    state_next      = ret_reg;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.ra_sel = RA_LKD;
                end
            end
            S_FREEFIN: begin
                cmd.mode_sel = MA_TGT;
                cmd.mode_we  = 1'b1;
                cmd.mode_val = MODE_FREE;
                ack_st_next  = 1'b0;
                state_next   = S_ACK;
            end
            S_CANFIN: begin
                cmd.mode_sel = MA_TGT;
                cmd.mode_we  = 1'b1;
                cmd.mode_val = MODE_ALLOC;
                ack_st_next  = 1'b0;
                state_next   = S_ACK;
            end
            // insert: write deadline, start at head
            S_ARMINS: begin
                cmd.mode_sel = MA_TGT;
                cmd.mode_we  = 1'b1;
                cmd.mode_val = MODE_RUN;
                cmd.dl_we    = 1'b1;
                cmd.rd_en    = 1'b1;
                cmd.ra_sel   = RA_HEAD;
                state_next   = S_IN_W;
            end
            S_IN_W: begin
                if (st.ins_hit) begin
                    cmd.lk_w_tgt = 1'b1;
                    if (st.cur_is_head) begin
                        cmd.head_sel = HD_TGT;
                        ack_st_next  = 1'b0;
                        state_next   = S_ACK;
                    end else begin
                        state_next = S_IN_P;
                    end
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.ra_sel = RA_LKD;
                end
            end
            S_IN_P: begin
                cmd.lk_w_prev = 1'b1;
                ack_st_next   = 1'b0;
                state_next    = S_ACK;
            end
            // alloc: lowest free slot from 1 up
            S_AL_SCAN: begin
                cmd.mode_sel = MA_IDX;
                if (st.idx_end) begin
                    ack_sel_next = AS_ZERO;
                    ack_st_next  = 1'b1;
                    state_next   = S_ACK;
                end else if (st.mode_free) begin
                    cmd.mode_we  = 1'b1;
                    cmd.mode_val = MODE_ALLOC;
                    cmd.mark_we  = 1'b1;
                    ack_sel_next = AS_IDX;
                    ack_st_next  = 1'b0;
                    state_next   = S_ACK;
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            // cancel all: one slot per pass
            S_CA_RD: begin
                if (st.idx_end) begin
                    ack_st_next = 1'b0;
                    state_next  = S_ACK;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.ra_sel = RA_IDX;
                    state_next = S_CA_CHK;
                end
            end
            S_CA_CHK: begin
                cmd.mode_sel = MA_IDX;
                state_next   = S_CA_RD;
                if (st.ca_match) begin
                    cmd.tgt_from_idx = 1'b1;
                    if (st.mode_run) begin
                        ret_next   = S_CA_FREE;
                        state_next = S_UL_S;
                    end else begin
                        cmd.mode_we  = 1'b1;
                        cmd.mode_val = MODE_FREE;
                        cmd.idx_inc  = 1'b1;
                    end
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_CA_FREE: begin
                cmd.mode_sel = MA_IDX;
                cmd.mode_we  = 1'b1;
                cmd.mode_val = MODE_FREE;
                cmd.idx_inc  = 1'b1;
                state_next   = S_CA_RD;
            end
            // tick: expiry walk from head
            S_TK: begin
                cmd.rd_en  = 1'b1;
                cmd.ra_sel = RA_HEAD;
                state_next = S_TK_CHK;
            end
            S_TK_CHK: begin
                cmd.mode_sel = MA_CUR;
                if (st.due) begin
                    if (!st.emit_block) begin
                        cmd.tk_step  = 1'b1;
                        cmd.mode_we  = 1'b1;
                        cmd.mode_val = MODE_ALLOC;
                        cmd.rd_en    = 1'b1;
                        cmd.ra_sel   = RA_LKD;
                    end
                end else begin
                    cmd.head_sel = HD_CUR;
                    state_next   = S_TK_FIN;
                end
            end
            S_TK_FIN: begin
                if (st.ts) begin
                    if (st.pend_v) begin
                        if (st.out_free) begin
                            cmd.out_pend  = 1'b1;
                            cmd.pend_last = 1'b0;
                        end
                    end else if (st.out_free) begin
                        cmd.out_ts = 1'b1;
                        state_next = S_IDLE;
                    end
                end else if (st.pend_v) begin
                    if (st.out_free) begin
                        cmd.out_pend  = 1'b1;
                        cmd.pend_last = 1'b1;
                        state_next    = S_IDLE;
                    end
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_ACK: begin
                cmd.ack_slot_sel = ack_sel_reg;
                cmd.ack_st       = ack_st_reg;
                if (st.out_free) begin
                    cmd.out_ack = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/core/stq_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stq_dp
// Datapath for the timer queue: slot memories, mode and mark flags, list
// head, tick count, walk registers and the output register.
// ----------------------------------------------------------------------------
module stq_dp #(
    parameter int NUM_SLOTS = stq_pkg::NUM_SLOTS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [2:0]        s_tuser,   // action
    input  wire logic [79:0]       s_tdata,   // slot_id, channel, tag_value,
                                              // auto_cancel, delay_ticks
    input  wire logic              cfg_valid,
    input  wire logic [4:0]        cfg_data,
    input  wire logic              m_tready,
    output logic                   m_tvalid,
    output logic [47:0]            m_tdata,   // result_slot, dest_channel,
                                              // delivered_tag, status
    output logic [1:0]             m_tuser,   // kind
    output logic                   m_tlast,
    input  wire stq_pkg::stq_cmd_t cmd,
    output stq_pkg::stq_stat_t     st
);
    import stq_pkg::*;

    localparam int SW = (NUM_SLOTS > 2) ? $clog2(NUM_SLOTS) : 1;
    localparam int IW = $clog2(NUM_SLOTS + 1);

    // memories
    logic [31:0] dl_mem [NUM_SLOTS];
    logic [SW-1:0] lk_mem [NUM_SLOTS];
    logic [39:0] tm_mem [NUM_SLOTS];

    logic [31:0]   dl_q;
    logic [SW-1:0] lk_q;
    logic [39:0]   tm_q;
    logic          rd0_reg;

    logic [1:0] mode_reg [NUM_SLOTS];
    logic       mark_reg [NUM_SLOTS];

    // request fields
    logic [2:0]    act_reg;
    logic [4:0]    sid_reg;
    logic [7:0]    chan_reg;
    logic [31:0]   tag_reg;
    logic          amark_reg;
    logic [31:0]   dlnew_reg;
    logic          ok_reg;
    logic [SW-1:0] tgt_reg;

    logic [SW-1:0] head_reg, cur_reg, prev_reg, nxt_reg;
    logic [31:0]   tick_reg;
    logic [IW-1:0] idx_reg;
    logic [4:0]    done_reg;
    logic          ts_reg;
    logic [4:0]    ttid_reg;

    logic          pend_v_reg;
    logic [4:0]    pend_slot_reg;
    logic [39:0]   pend_tm_reg;

    logic          ov_reg;
    logic [1:0]    okind_reg;
    logic [4:0]    oslot_reg;
    logic [7:0]    och_reg;
    logic [31:0]   otag_reg;
    logic          ost_reg;
    logic          olast_reg;

    logic [31:0]   dl_rd;
    logic [SW-1:0] lk_rd;
    logic [SW-1:0] ra;
    logic [SW-1:0] maddr;
    logic [1:0]    mode_rd;
    logic          out_free;
    logic          cur_task;
    logic [4:0]    in_sid;
    logic [SW-1:0] wa;
    logic [SW-1:0] wd;
    logic          lk_we;
    logic [4:0]    ack_slot;

    // sentinel overrides on slot 0
    assign dl_rd = rd0_reg ? END_DEADLINE : dl_q;
    assign lk_rd = rd0_reg ? '0 : lk_q;

    assign in_sid   = s_tdata[4:0];
    assign out_free = !ov_reg || m_tready;
    assign cur_task = (32'(cur_reg) == 32'(ttid_reg));

    // read address select
    always_comb begin
        case (cmd.ra_sel)
            RA_TGT:  ra = tgt_reg;
            RA_HEAD: ra = head_reg;
            RA_LKD:  ra = lk_rd;
            RA_IDX:  ra = idx_reg[SW-1:0];
            default: ra = tgt_reg;
        endcase
    end

    // mode / mark address select
    always_comb begin
        case (cmd.mode_sel)
            MA_TGT:  maddr = tgt_reg;
            MA_IDX:  maddr = idx_reg[SW-1:0];
            MA_CUR:  maddr = cur_reg;
            default: maddr = tgt_reg;
        endcase
    end
    assign mode_rd = mode_reg[maddr];

    // link write port
    always_comb begin
        lk_we = cmd.lk_w_unlink || cmd.lk_w_tgt || cmd.lk_w_prev;
        if (cmd.lk_w_unlink) begin
            wa = cur_reg;
            wd = nxt_reg;
        end else if (cmd.lk_w_tgt) begin
            wa = tgt_reg;
            wd = cur_reg;
        end else begin
            wa = prev_reg;
            wd = tgt_reg;
        end
    end

    // slot memories
    always_ff @(posedge aclk) begin
        if (cmd.dl_we) begin
            dl_mem[tgt_reg] <= dlnew_reg;
        end
        if (lk_we) begin
            lk_mem[wa] <= wd;
        end
        if (cmd.tm_we) begin
            tm_mem[tgt_reg] <= {chan_reg, tag_reg};
        end
        if (cmd.rd_en) begin
            dl_q    <= dl_mem[ra];
            lk_q    <= lk_mem[ra];
            tm_q    <= tm_mem[ra];
            rd0_reg <= (ra == '0);
            cur_reg <= ra;
            prev_reg <= cur_reg;
        end
    end

    // mode and mark flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                mode_reg[i] <= (i == 0) ? MODE_RUN : MODE_FREE;
                mark_reg[i] <= 1'b0;
            end
        end else begin
            if (cmd.mode_we) begin
                mode_reg[maddr] <= cmd.mode_val;
            end
            if (cmd.mark_we) begin
                mark_reg[maddr] <= cmd.mark_item ? amark_reg : 1'b0;
            end
        end
    end

    // request capture
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            act_reg   <= s_tuser;
            sid_reg   <= in_sid;
            chan_reg  <= s_tdata[12:5];
            tag_reg   <= s_tdata[44:13];
            amark_reg <= s_tdata[45];
            dlnew_reg <= s_tdata[77:46] + tick_reg;
            ok_reg    <= (in_sid != 5'd0) && (32'(in_sid) < NUM_SLOTS);
            tgt_reg   <= SW'(in_sid);
        end else if (cmd.tgt_from_idx) begin
            tgt_reg <= idx_reg[SW-1:0];
        end
        if (cmd.nxt_load) begin
            nxt_reg <= lk_rd;
        end
        if (cmd.tk_step && !cur_task) begin
            pend_slot_reg <= 5'(cur_reg);
            pend_tm_reg   <= tm_q;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg   <= '0;
            tick_reg   <= '0;
            idx_reg    <= '0;
            done_reg   <= '0;
            ts_reg     <= 1'b0;
            ttid_reg   <= '0;
            pend_v_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                ttid_reg <= cfg_data;
            end
            if (cmd.capture) begin
                done_reg   <= '0;
                ts_reg     <= 1'b0;
                pend_v_reg <= 1'b0;
                if (s_tuser == ACT_TICK) begin
                    tick_reg <= tick_reg + 32'd1;
                end
            end
            // successor of the target comes straight from the link read
            case (cmd.head_sel)
                HD_NXT:  head_reg <= lk_rd;
                HD_TGT:  head_reg <= tgt_reg;
                HD_CUR:  head_reg <= cur_reg;
                default: head_reg <= head_reg;
            endcase
            if (cmd.idx_init) begin
                idx_reg <= IW'(1);
            end else if (cmd.idx_inc) begin
                idx_reg <= idx_reg + IW'(1);
            end
            if (cmd.tk_step) begin
                done_reg <= done_reg + 5'd1;
                if (cur_task) begin
                    ts_reg <= 1'b1;
                end else begin
                    pend_v_reg <= 1'b1;
                end
            end
            if (cmd.out_pend) begin
                pend_v_reg <= 1'b0;
            end
        end
    end

    // ack slot select
    always_comb begin
        case (cmd.ack_slot_sel)
            AS_SID:  ack_slot = sid_reg;
            AS_IDX:  ack_slot = 5'(idx_reg);
            AS_ZERO: ack_slot = 5'd0;
            default: ack_slot = sid_reg;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else begin
            if (m_tready) begin
                ov_reg <= 1'b0;
            end
            if (cmd.out_ack || cmd.out_ts || cmd.out_pend ||
                (cmd.tk_step && !cur_task && pend_v_reg)) begin
                ov_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_ack) begin
            okind_reg <= KIND_ACK;
            oslot_reg <= ack_slot;
            och_reg   <= 8'd0;
            otag_reg  <= 32'd0;
            ost_reg   <= cmd.ack_st;
            olast_reg <= 1'b1;
        end else if (cmd.out_ts) begin
            okind_reg <= KIND_SWITCH;
            oslot_reg <= ttid_reg;
            och_reg   <= 8'd0;
            otag_reg  <= 32'd0;
            ost_reg   <= 1'b0;
            olast_reg <= 1'b1;
        end else if (cmd.out_pend || (cmd.tk_step && !cur_task && pend_v_reg)) begin
            okind_reg <= KIND_DELIVER;
            oslot_reg <= pend_slot_reg;
            och_reg   <= pend_tm_reg[39:32];
            otag_reg  <= pend_tm_reg[31:0];
            ost_reg   <= 1'b0;
            olast_reg <= cmd.out_pend ? cmd.pend_last : 1'b0;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {2'b00, ost_reg, otag_reg, och_reg, oslot_reg};
    assign m_tuser  = okind_reg;
    assign m_tlast  = olast_reg;

    // status to controller
    always_comb begin
        st.act         = act_reg;
        st.ok          = ok_reg;
        st.mode_free   = (mode_rd == MODE_FREE);
        st.mode_run    = (mode_rd == MODE_RUN);
        st.head_is_tgt = (head_reg == tgt_reg);
        st.lk_hit      = (lk_rd == tgt_reg);
        st.ins_hit     = (dlnew_reg <= dl_rd);
        st.cur_is_head = (cur_reg == head_reg);
        st.due         = !rd0_reg && (32'(done_reg) < BURST_MAX) && (dl_rd <= tick_reg);
        st.emit_block  = !cur_task && pend_v_reg && !out_free;
        st.idx_end     = (32'(idx_reg) >= NUM_SLOTS);
        st.ca_match    = (mode_rd != MODE_FREE) && mark_reg[maddr] &&
                         (tm_q[39:32] == chan_reg);
        st.pend_v      = pend_v_reg;
        st.ts          = ts_reg;
        st.out_free    = out_free;
    end

endmodule
`default_nettype wire

// ===== rtl/core/sorted_timeout_queue_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_timeout_queue_top
// Pool of timers in a deadline-sorted linked list with a sentinel slot.
// Free, cancel and arm walk the list to unlink a running timer; arm walks it again
//   to insert; alloc and cancel all scan the slots; tick walks expired entries from
//   the head. One request in flight; next accepted the cycle after the last result
//   enters the output register. Reset: synchronous active-low, list empty, all
//   slots but the sentinel free, tick count and task timer id zero.
// ----------------------------------------------------------------------------
module sorted_timeout_queue_top #(
    parameter int NUM_SLOTS = stq_pkg::NUM_SLOTS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,   // slot_id[4:0], channel[12:5],
                                        // tag_value[44:13], auto_cancel[45],
                                        // delay_ticks[77:46]
    input  wire logic [2:0]  s_tuser,   // action[2:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // result_slot[4:0], dest_channel[12:5],
                                        // delivered_tag[44:13], status[45]
    output logic [1:0]       m_tuser,   // kind[1:0]
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [4:0]  cfg_data   // task_timer_id
);
    import stq_pkg::*;

    stq_cmd_t  cmd;
    stq_stat_t st;
    logic      s_ready_int;
    logic      in_valid;

    assign cfg_ready = 1'b1;
    assign s_tready  = s_ready_int;
    assign in_valid  = s_tvalid;

    // sequencer
    stq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (in_valid),
        .s_tready (s_ready_int),
        .st       (st),
        .cmd      (cmd)
    );

    // datapath
    stq_dp #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .st        (st)
    );

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sorted timeout queue. A scoreboard keeps its
// own copy of the timer pool, predicts the acks, deliveries and task switch
// requests of each accepted request, and compares every result in order.
// ----------------------------------------------------------------------------
import stq_pkg::*;

typedef struct {
    logic [1:0]  kind;
    logic [4:0]  slot;
    logic [7:0]  chan;
    logic [31:0] tag;
    logic        status;
    logic        last;
} timer_result_t;

class timer_pool_scoreboard;
    logic [31:0] deadline[32];
    logic [1:0]  mode[32];
    logic        mark[32];
    logic [7:0]  chan[32];
    logic [31:0] tag[32];
    logic [4:0]  link[32];
    logic [4:0]  head;
    logic [31:0] ticks;
    logic [4:0]  switch_slot;
    timer_result_t pending_results[$];
    int errors;

    function new();
        for (int i = 0; i < 32; i++) begin
            deadline[i] = 0; mode[i] = MODE_FREE; mark[i] = 0;
            chan[i] = 0; tag[i] = 0; link[i] = 0;
        end
        deadline[0] = END_DEADLINE;
        mode[0] = MODE_RUN;
        head = 0; ticks = 0; switch_slot = 0; errors = 0;
    endfunction

    function void push(logic [1:0] k, logic [4:0] s, logic [7:0] c, logic [31:0] t,
                       logic st, logic l);
        timer_result_t r;
        r.kind = k; r.slot = s; r.chan = c; r.tag = t; r.status = st; r.last = l;
        pending_results.push_back(r);
    endfunction

    function void unlink(logic [4:0] s);
        logic [4:0] p;
        if (head == s) begin
            head = link[s];
            return;
        end
        p = head;
        for (int n = 0; n < 32; n++) begin
            if (link[p] == s) begin
                link[p] = link[s];
                return;
            end
            p = link[p];
        end
    endfunction

    // insert before the first entry with an equal or later deadline
    function void insert(logic [4:0] s, logic [31:0] d);
        logic [4:0] prv, cur;
        deadline[s] = d;
        cur = head;
        if (d <= deadline[cur]) begin
            link[s] = cur;
            head = s;
            return;
        end
        for (int n = 0; n < 32; n++) begin
            prv = cur;
            cur = link[cur];
            if (cur == 0 || d <= deadline[cur]) begin
                link[prv] = s;
                link[s] = cur;
                return;
            end
        end
    endfunction

    function logic stop_timer(logic [4:0] s);
        if (mode[s] != MODE_RUN) return 1'b1;
        unlink(s);
        mode[s] = MODE_ALLOC;
        return 1'b0;
    endfunction

    function void note_request(logic [2:0] act, logic [4:0] sid, logic [7:0] c,
                               logic [31:0] t, logic m, logic [31:0] dly);
        logic ok, st, ts, dummy;
        logic [4:0] cur;
        int done, first;
        ok = (sid != 0);
        st = 1'b1;
        case (act)
            ACT_ALLOC: begin
                for (int i = 1; i < 32; i++) begin
                    if (mode[i] == MODE_FREE) begin
                        mode[i] = MODE_ALLOC;
                        mark[i] = 1'b0;
                        push(KIND_ACK, i[4:0], 8'd0, 32'd0, 1'b0, 1'b1);
                        return;
                    end
                end
                push(KIND_ACK, 5'd0, 8'd0, 32'd0, 1'b1, 1'b1);
                return;
            end
            ACT_FREE: if (ok) begin
                dummy = stop_timer(sid);
                mode[sid] = MODE_FREE;
                st = 1'b0;
            end
            ACT_SETTAG: if (ok) begin
                chan[sid] = c; tag[sid] = t; mark[sid] = m;
                st = 1'b0;
            end
            ACT_ARM: if (ok && mode[sid] != MODE_FREE) begin
                dummy = stop_timer(sid);
                mode[sid] = MODE_RUN;
                insert(sid, dly + ticks);
                st = 1'b0;
            end
            ACT_CANCEL: if (ok) st = stop_timer(sid);
            ACT_CANCALL: begin
                for (int i = 1; i < 32; i++) begin
                    if (mode[i] != MODE_FREE && mark[i] && chan[i] == c) begin
                        dummy = stop_timer(i[4:0]);
                        mode[i] = MODE_FREE;
                    end
                end
                st = 1'b0;
            end
            ACT_TICK: begin
                // expiry walk in list order, burst limited
                first = pending_results.size();
                done = 0; ts = 1'b0;
                ticks = ticks + 1;
                cur = head;
                while (cur != 0 && done < BURST_MAX && deadline[cur] <= ticks) begin
                    mode[cur] = MODE_ALLOC;
                    if (cur == switch_slot) ts = 1'b1;
                    else push(KIND_DELIVER, cur, chan[cur], tag[cur], 1'b0, 1'b0);
                    done++;
                    cur = link[cur];
                end
                head = cur;
                if (ts) push(KIND_SWITCH, switch_slot, 8'd0, 32'd0, 1'b0, 1'b0);
                if (pending_results.size() > first)
                    pending_results[pending_results.size() - 1].last = 1'b1;
                return;
            end
            default: ;
        endcase
        push(KIND_ACK, sid, 8'd0, 32'd0, st, 1'b1);
    endfunction

    function void check_result(timer_result_t got);
        timer_result_t exp_r;
        if (pending_results.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected result kind=%0d slot=%0d", got.kind, got.slot);
            return;
        end
        exp_r = pending_results.pop_front();
        if (got.kind !== exp_r.kind || got.slot !== exp_r.slot || got.chan !== exp_r.chan
            || got.tag !== exp_r.tag || got.status !== exp_r.status
            || got.last !== exp_r.last) begin
            errors++;
            if (errors <= 10)
                $display("mismatch exp k=%0d s=%0d c=%0h t=%0h st=%0d l=%0d / got k=%0d s=%0d c=%0h t=%0h st=%0d l=%0d",
                         exp_r.kind, exp_r.slot, exp_r.chan, exp_r.tag, exp_r.status,
                         exp_r.last, got.kind, got.slot, got.chan, got.tag, got.status,
                         got.last);
        end
    endfunction
endclass

module testbench;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 300;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [4:0]  cfg_data = '0;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int cycles = 0;
    logic tag_written[32];
    timer_pool_scoreboard sb;

    sorted_timeout_queue_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // receiver back pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // result monitor
    always @(posedge aclk) begin
        timer_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.slot = m_tdata[4:0];
            got.chan = m_tdata[12:5];
            got.tag = m_tdata[44:13];
            got.status = m_tdata[45];
            got.kind = m_tuser;
            got.last = m_tlast;
            sb.check_result(got);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[sorted_timeout_queue_top] ERROR");
            $finish;
        end
    end

    task automatic send_request(logic [2:0] act, logic [4:0] sid, logic [7:0] c,
                                logic [31:0] t, logic m, logic [31:0] dly);
        int gap;
        if ($urandom_range(99) < tx_idle_pct) begin
            gap = $urandom_range(4, 1);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= {2'b00, dly, m, t, c, sid};
        do @(posedge aclk); while (!s_tready);
        if (act == ACT_SETTAG && sid != 0) tag_written[sid] = 1'b1;
        sb.note_request(act, sid, c, t, m, dly);
    endtask

    task automatic write_switch_slot(logic [4:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.switch_slot = v;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic logic [4:0] pick_slot();
        logic [4:0] s;
        s = 5'($urandom_range(31, 1));
        for (int n = 0; n < 4 && sb.mode[s] == MODE_FREE; n++)
            s = 5'($urandom_range(31, 1));
        return s;
    endfunction

    function automatic logic [7:0] pick_channel();
        logic [7:0] c;
        case ($urandom_range(3))
            0: c = 8'd3;
            1: c = 8'd7;
            2: c = 8'd200;
            default: c = 8'($urandom);
        endcase
        return c;
    endfunction

    function automatic logic [31:0] pick_delay();
        if ($urandom_range(9) == 0) return $urandom;
        return 32'($urandom_range(12));
    endfunction

    // random mix of actions, mostly well-formed timer lifecycles
    task automatic random_requests(int count);
        int r;
        logic [4:0] s;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            s = pick_slot();
            if (r < 16) send_request(ACT_ALLOC, 5'($urandom), 8'($urandom), $urandom,
                                     1'($urandom), $urandom);
            else if (r < 23) send_request(ACT_FREE, s, 8'($urandom), $urandom,
                                          1'($urandom), $urandom);
            else if (r < 40 || (r < 62 && sb.mode[s] != MODE_FREE && !tag_written[s]))
                send_request(ACT_SETTAG, s, pick_channel(), $urandom, 1'($urandom),
                             $urandom);
            else if (r < 62) send_request(ACT_ARM, s, 8'($urandom), $urandom,
                                          1'($urandom), pick_delay());
            else if (r < 70) send_request(ACT_CANCEL, s, 8'($urandom), $urandom,
                                          1'($urandom), $urandom);
            else if (r < 75) send_request(ACT_CANCALL, 5'($urandom), pick_channel(),
                                          $urandom, 1'($urandom), $urandom);
            else if (r < 96) send_request(ACT_TICK, 5'($urandom), 8'($urandom), $urandom,
                                          1'($urandom), $urandom);
            else if (r < 98) send_request(3'd7, 5'($urandom), 8'($urandom), $urandom,
                                          1'($urandom), $urandom);
            else send_request(3'($urandom_range(4, 1)), 5'd0, 8'($urandom), $urandom,
                              1'($urandom), $urandom);
        end
    endtask

    initial begin
        sb = new();
        for (int i = 0; i < 32; i++) tag_written[i] = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // phase one: sender idles lightly, receiver heavily
        tx_idle_pct = 29; rx_idle_pct = 62;
        write_switch_slot(5'd2);
        send_request(ACT_ALLOC, 5'd0, 8'd0, 32'd0, 1'b0, 32'd0);
        send_request(ACT_ALLOC, 5'd0, 8'd0, 32'd0, 1'b0, 32'd0);
        send_request(ACT_SETTAG, 5'd1, 8'd0, 32'd0, 1'b0, 32'd0);
        send_request(ACT_SETTAG, 5'd2, 8'hff, 32'hffff_ffff, 1'b1, 32'hffff_ffff);
        send_request(ACT_ARM, 5'd1, 8'd0, 32'd0, 1'b0, 32'd0);
        // equal deadline goes ahead of the earlier one
        send_request(ACT_ARM, 5'd2, 8'd0, 32'd0, 1'b0, 32'd0);
        send_request(ACT_TICK, 5'd0, 8'd0, 32'd0, 1'b0, 32'd0);
        // deadline wraps past the count
        send_request(ACT_ARM, 5'd2, 8'd0, 32'd0, 1'b0, 32'hffff_ffff);
        send_request(ACT_ARM, 5'd1, 8'd0, 32'd0, 1'b0, 32'd3);
        send_request(ACT_CANCEL, 5'd1, 8'd0, 32'd0, 1'b0, 32'd0);
        send_request(ACT_CANCEL, 5'd1, 8'd0, 32'd0, 1'b0, 32'd0);
        send_request(ACT_TICK, 5'd31, 8'hff, 32'hffff_ffff, 1'b1, 32'hffff_ffff);
        // quiet tick
        send_request(ACT_TICK, 5'd0, 8'd0, 32'd0, 1'b0, 32'd0);
        // sentinel slot is rejected
        send_request(ACT_FREE, 5'd0, 8'd0, 32'd0, 1'b0, 32'd0);
        send_request(ACT_SETTAG, 5'd0, 8'd9, 32'd9, 1'b1, 32'd0);
        send_request(ACT_ARM, 5'd0, 8'd0, 32'd0, 1'b0, 32'd1);
        send_request(ACT_CANCEL, 5'd0, 8'd0, 32'd0, 1'b0, 32'd0);
        send_request(3'd7, 5'd31, 8'hff, 32'hffff_ffff, 1'b1, 32'hffff_ffff);
        send_request(ACT_ALLOC, 5'd0, 8'd0, 32'd0, 1'b0, 32'd0);
        send_request(ACT_FREE, 5'd3, 8'd0, 32'd0, 1'b0, 32'd0);
        send_request(ACT_ARM, 5'd3, 8'd0, 32'd0, 1'b0, 32'd1);
        send_request(ACT_ARM, 5'd2, 8'd0, 32'd0, 1'b0, 32'd5);
        send_request(ACT_CANCALL, 5'd0, 8'hff, 32'd0, 1'b0, 32'd0);
        send_request(ACT_ARM, 5'd31, 8'd0, 32'd0, 1'b0, 32'd1);
        random_requests(40);
        drain();

        // phase two: the other way round, top slot as task timer
        tx_idle_pct = 62; rx_idle_pct = 29;
        write_switch_slot(5'd31);
        random_requests(40);
        drain();

        // phase three: no idling, first no task timer, then a random one
        tx_idle_pct = 0; rx_idle_pct = 0;
        write_switch_slot(5'd0);
        random_requests(25);
        drain();
        write_switch_slot(5'($urandom_range(31, 1)));
        random_requests(25);
        drain();

        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("[sorted_timeout_queue_top] OK");
        else
            $display("[sorted_timeout_queue_top] ERROR");
        $finish;
    end
endmodule
